// ===== hdl/bcop_pkg.sv =====
// Shared types and constants for the box chunk offset patcher.
package bcop_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SLACK  = 3'd1,
        PH_SKIP   = 3'd2,
        PH_THEAD  = 3'd3,
        PH_ENTRY  = 3'd4,
        PH_TAIL   = 3'd5,
        PH_ERROR  = 3'd6,
        PH_DONE   = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_STCO  = 2'd1,
        KIND_CO64  = 2'd2
    } t_kind;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_LONG_TRUNC = 3'd1;
    localparam logic [2:0] ERR_SIZE_LOW  = 3'd2;
    localparam logic [2:0] ERR_SIZE_BIG  = 3'd3;
    localparam logic [2:0] ERR_TBL_SHORT = 3'd4;
    localparam logic [2:0] ERR_COUNT_BIG = 3'd5;
    localparam logic [2:0] ERR_NEST_DEEP = 3'd6;

    localparam logic [31:0] TYPE_STCO = 32'h7374636F;
    localparam logic [31:0] TYPE_CO64 = 32'h636F3634;
    localparam logic [31:0] TYPE_MOOV = 32'h6D6F6F76;
    localparam logic [31:0] TYPE_TRAK = 32'h7472616B;
    localparam logic [31:0] TYPE_MDIA = 32'h6D646961;
    localparam logic [31:0] TYPE_MINF = 32'h6D696E66;
    localparam logic [31:0] TYPE_STBL = 32'h7374626C;

    localparam int unsigned PREAMBLE = 8;

    // One processed input byte as seen by the output queue.
    typedef struct packed {
        logic        data_valid;  // patched/pass bytes present
        logic [3:0]  n_bytes;     // 1, 4 or 8
        logic [63:0] bytes;       // MSB first, right aligned
        logic        ended;
        logic [2:0]  err;
        logic        ovf;
    } t_run;

endpackage

// ===== hdl/bcop_parser.sv =====
// Box parser: per byte, walks the box tree and patches offset table entries.
module bcop_parser
    import bcop_pkg::*;
#(
    parameter int MAX_NESTING = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_box_len,
    input  logic        i_in_valid,
    input  logic [7:0]  i_in_byte,
    output logic        o_run_valid,
    output t_run        o_run
);
    localparam int LEVELS = MAX_NESTING + 1;
    localparam int LW = $clog2(LEVELS);

    logic [31:0]   r_lvl [LEVELS];
    logic [LW-1:0] r_nest;
    logic [7:0]    r_hdr [16];
    logic [4:0]    r_hfill;
    t_phase        r_phase;
    t_kind         r_kind;
    logic [31:0]   r_eleft;
    logic [63:0]   r_acc;
    logic [3:0]    r_efill;
    logic          r_ovf;
    logic [2:0]    r_err;
    logic [31:0]   r_cons;
    logic [31:0]   r_bleft;
    logic [31:0]   r_total;
    logic          r_started;

    logic [31:0]   n_lvl [LEVELS];
    logic [LW-1:0] n_nest;
    logic [4:0]    n_hfill;
    t_phase        n_phase;
    t_kind         n_kind;
    logic [31:0]   n_eleft;
    logic [63:0]   n_acc;
    logic [3:0]    n_efill;
    logic          n_ovf;
    logic [2:0]    n_err;
    logic [31:0]   n_bleft;
    logic          hdr_we;
    t_run          run;

    // Header byte view: last stored bytes plus the incoming one.
    logic [7:0]    hb [16];
    logic [31:0]   s32, type32, s_lo, s_hi, cnt;
    logic [63:0]   size64, body64, sum64;
    logic [32:0]   hsize, sum33;
    logic          hdr_fire, to_end, do_settle, w4;
    logic [LW-1:0] cur;
    logic [31:0]   cur_rem;

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            hb[k] = r_hdr[k];
        end
        hb[r_hfill[3:0]] = i_in_byte;
        s32    = {hb[0], hb[1], hb[2], hb[3]};
        type32 = {hb[4], hb[5], hb[6], hb[7]};
        s_hi   = {hb[8], hb[9], hb[10], hb[11]};
        s_lo   = {hb[12], hb[13], hb[14], hb[15]};
    end

    always_comb begin
        logic [LW-1:0] lv;
        logic [31:0]   rem;
        logic [63:0]   nacc;
        logic [31:0]   nbl;
        logic [31:0]   q;
        n_lvl     = r_lvl;
        n_nest    = r_nest;
        n_hfill   = r_hfill;
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_eleft   = r_eleft;
        n_acc     = r_acc;
        n_efill   = r_efill;
        n_ovf     = r_ovf;
        n_err     = r_err;
        n_bleft   = r_bleft;
        hdr_we    = 1'b0;
        do_settle = 1'b0;
        hdr_fire  = 1'b0;
        to_end    = 1'b0;
        size64    = '0;
        hsize     = '0;
        body64    = '0;
        sum64     = '0;
        sum33     = '0;
        cnt       = '0;
        w4        = (r_kind == KIND_STCO);
        cur       = r_nest;
        cur_rem   = r_lvl[r_nest];
        nacc      = {r_acc[55:0], i_in_byte};
        nbl       = r_bleft - 32'd1;
        q         = '0;
        rem       = '0;
        lv        = '0;
        run.data_valid = 1'b1;
        run.n_bytes    = 4'd1;
        run.bytes      = {56'd0, i_in_byte};
        run.ended      = 1'b0;

        if (!r_started) begin
            // First byte: root level set to the configured size, then settle.
            for (int k = 0; k < LEVELS; k++) begin
                n_lvl[k] = '0;
            end
            n_lvl[0] = i_box_len;
            n_nest   = '0;
            cur      = '0;
            n_hfill  = '0;
            if (i_box_len == 32'd0) begin
                n_phase = PH_DONE;
            end else if (i_box_len < 32'(PREAMBLE)) begin
                n_phase = PH_SLACK;
            end else begin
                n_phase = PH_HEADER;
            end
        end

        if (r_cons >= (r_started ? r_total : i_box_len)) begin
            run.data_valid = 1'b0;
            run.bytes      = '0;
        end else begin
            run.ended = ((r_cons + 32'd1) == (r_started ? r_total : i_box_len));
            cur_rem   = n_lvl[cur];
            case (n_phase)
                PH_HEADER: begin
                    hdr_we  = 1'b1;
                    n_hfill = r_hfill + 5'd1;
                    rem     = cur_rem - 32'd1;
                    n_lvl[cur] = rem;
                    if (n_hfill == 5'd8) begin
                        if (s32 == 32'd1) begin
                            if (rem < 32'd8) begin
                                if (n_err == ERR_NONE) n_err = ERR_LONG_TRUNC;
                                n_phase = PH_ERROR;
                            end
                        end else begin
                            hdr_fire = 1'b1;
                            size64   = {32'd0, s32};
                            hsize    = 33'd8;
                            to_end   = (s32 == 32'd0);
                        end
                    end else if (n_hfill >= 5'd16) begin
                        hdr_fire = 1'b1;
                        size64   = {s_hi, s_lo};
                        hsize    = 33'd16;
                    end
                    if (hdr_fire) begin
                        if (to_end) size64 = {31'd0, hsize} + {32'd0, rem};
                        if (size64 < {31'd0, hsize}) begin
                            if (n_err == ERR_NONE) n_err = ERR_SIZE_LOW;
                            n_phase = PH_ERROR;
                        end else begin
                            body64 = size64 - {31'd0, hsize};
                            if (body64 > {32'd0, rem}) begin
                                if (n_err == ERR_NONE) n_err = ERR_SIZE_BIG;
                                n_phase = PH_ERROR;
                            end else begin
                                n_lvl[cur] = rem - body64[31:0];
                                if (type32 == TYPE_STCO || type32 == TYPE_CO64) begin
                                    if (body64 < 64'd8) begin
                                        if (n_err == ERR_NONE) n_err = ERR_TBL_SHORT;
                                        n_phase = PH_ERROR;
                                    end else begin
                                        n_kind  = (type32 == TYPE_STCO) ? KIND_STCO
                                                                        : KIND_CO64;
                                        n_bleft = body64[31:0];
                                        n_acc   = '0;
                                        n_efill = '0;
                                        n_phase = PH_THEAD;
                                    end
                                end else if (type32 == TYPE_MOOV || type32 == TYPE_TRAK ||
                                             type32 == TYPE_MDIA || type32 == TYPE_MINF ||
                                             type32 == TYPE_STBL) begin
                                    if (cur >= LW'(MAX_NESTING)) begin
                                        if (n_err == ERR_NONE) n_err = ERR_NEST_DEEP;
                                        n_phase = PH_ERROR;
                                    end else begin
                                        n_nest = cur + LW'(1);
                                        n_lvl[n_nest] = body64[31:0];
                                        do_settle = 1'b1;
                                    end
                                end else begin
                                    n_kind  = KIND_OTHER;
                                    n_bleft = body64[31:0];
                                    if (body64 == 64'd0) do_settle = 1'b1;
                                    else n_phase = PH_SKIP;
                                end
                            end
                        end
                    end
                end
                PH_SLACK: begin
                    n_lvl[cur] = cur_rem - 32'd1;
                    if (n_lvl[cur] == 32'd0) do_settle = 1'b1;
                end
                PH_SKIP, PH_TAIL: begin
                    n_bleft = nbl;
                    if (nbl == 32'd0) do_settle = 1'b1;
                end
                PH_THEAD: begin
                    n_acc   = nacc;
                    n_efill = r_efill + 4'd1;
                    n_bleft = nbl;
                    if (n_efill >= 4'd8) begin
                        cnt     = nacc[31:0];
                        n_acc   = '0;
                        n_efill = '0;
                        q = w4 ? {2'd0, nbl[31:2]} : {3'd0, nbl[31:3]};
                        if (cnt > q) begin
                            if (n_err == ERR_NONE) n_err = ERR_COUNT_BIG;
                            n_phase = PH_ERROR;
                        end else begin
                            n_eleft = cnt;
                            if (cnt != 32'd0) n_phase = PH_ENTRY;
                            else if (nbl == 32'd0) do_settle = 1'b1;
                            else n_phase = PH_TAIL;
                        end
                    end
                end
                PH_ENTRY: begin
                    n_acc   = nacc;
                    n_efill = r_efill + 4'd1;
                    n_bleft = nbl;
                    if (n_efill < (w4 ? 4'd4 : 4'd8)) begin
                        run.data_valid = 1'b0;
                        run.bytes      = '0;
                    end else begin
                        if (w4) begin
                            sum33 = {1'b0, nacc[31:0]} + {1'b0, r_total};
                            if (sum33[32]) n_ovf = 1'b1;
                            run.n_bytes = 4'd4;
                            run.bytes   = {32'd0, sum33[31:0]};
                        end else begin
                            sum64 = nacc + {32'd0, r_total};
                            run.n_bytes = 4'd8;
                            run.bytes   = sum64;
                        end
                        n_acc   = '0;
                        n_efill = '0;
                        n_eleft = r_eleft - 32'd1;
                        if (n_eleft == 32'd0) begin
                            if (nbl == 32'd0) do_settle = 1'b1;
                            else n_phase = PH_TAIL;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (do_settle) begin
            // Pop exhausted levels; stack is shallow so this is a short chain.
            lv = n_nest;
            for (int k = LEVELS - 1; k > 0; k--) begin
                if (lv == LW'(k) && n_lvl[k] == 32'd0) lv = LW'(k - 1);
            end
            n_nest  = lv;
            n_hfill = '0;
            if (n_lvl[lv] == 32'd0) n_phase = PH_DONE;
            else if (n_lvl[lv] < 32'(PREAMBLE)) n_phase = PH_SLACK;
            else n_phase = PH_HEADER;
        end
        run.err = n_err;
        run.ovf = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nest    <= '0;
            r_hfill   <= '0;
            r_phase   <= PH_HEADER;
            r_kind    <= KIND_OTHER;
            r_eleft   <= '0;
            r_acc     <= '0;
            r_efill   <= '0;
            r_ovf     <= 1'b0;
            r_err     <= ERR_NONE;
            r_cons    <= '0;
            r_bleft   <= '0;
            r_total   <= '0;
            r_started <= 1'b0;
            o_run_valid <= 1'b0;
        end else begin
            o_run_valid <= i_in_valid;
            if (i_in_valid) begin
                r_started <= 1'b1;
                if (!r_started) r_total <= i_box_len;
                if (run.data_valid || r_cons < (r_started ? r_total : i_box_len)) begin
                    if (r_cons < (r_started ? r_total : i_box_len)) r_cons <= r_cons + 32'd1;
                end
                r_nest  <= n_nest;
                r_hfill <= n_hfill;
                r_phase <= n_phase;
                r_kind  <= n_kind;
                r_eleft <= n_eleft;
                r_acc   <= n_acc;
                r_efill <= n_efill;
                r_ovf   <= n_ovf;
                r_err   <= n_err;
                r_bleft <= n_bleft;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid) begin
            r_lvl <= n_lvl;
            if (hdr_we) r_hdr[r_hfill[3:0]] <= i_in_byte;
        end
        o_run <= run;
    end

    property p_nest_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_nest <= LW'(MAX_NESTING);
    endproperty
    a_nest_bound: assert property (p_nest_bound) else $error("nesting above limit");

    property p_err_sticky;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_err != ERR_NONE) |=> (r_err == $past(r_err));
    endproperty
    a_err_sticky: assert property (p_err_sticky) else $error("error code changed");

    property p_ovf_sticky;
        @(posedge i_clk) disable iff (!i_rst_n) r_ovf |=> r_ovf;
    endproperty
    a_ovf_sticky: assert property (p_ovf_sticky) else $error("overflow flag cleared");

    property p_cons_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_started |-> (r_cons <= r_total);
    endproperty
    a_cons_bound: assert property (p_cons_bound) else $error("consumed past box end");

endmodule

// ===== hdl/bcop_outq.sv =====
// Output queue: holds per-byte runs; one result a cycle out unless stalled.
module bcop_outq
    import bcop_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_run_valid,
    input  t_run       i_run,
    output logic       o_almost_full,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte,
    output logic       o_byte_valid,
    output logic       o_run_end,
    output logic       o_stream_end,
    output logic [2:0] o_error_code,
    output logic       o_offset_overflow
);
    localparam int DEPTH = 4;
    localparam int AW = 2;

    t_run          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic [3:0]    r_idx;
    t_run          head;
    logic          pop, last;
    logic [5:0]    sh;

    assign head = r_mem[r_rp];
    assign last = (r_idx == head.n_bytes - 4'd1);
    assign pop  = o_valid && !i_stall && last;
    assign sh   = 6'((head.n_bytes - 4'd1 - r_idx) * 8);

    assign o_valid          = (r_cnt != '0);
    assign o_byte           = 8'(head.bytes >> sh);
    assign o_byte_valid     = head.data_valid;
    assign o_run_end        = last;
    assign o_stream_end     = last && head.ended;
    assign o_error_code     = head.err;
    assign o_offset_overflow = head.ovf;
    // Two free slots: one for a request in flight, one for the next.
    assign o_almost_full    = (r_cnt >= (AW + 1)'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            if (i_run_valid) r_wp <= r_wp + AW'(1);
            if (pop) begin
                r_rp  <= r_rp + AW'(1);
                r_idx <= '0;
            end else if (o_valid && !i_stall) begin
                r_idx <= r_idx + 4'd1;
            end
            r_cnt <= r_cnt + (AW + 1)'(i_run_valid) - (AW + 1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run_valid) r_mem[r_wp] <= i_run;
    end

    property p_no_overrun;
        @(posedge i_clk) disable iff (!i_rst_n) i_run_valid |-> (r_cnt < (AW + 1)'(DEPTH));
    endproperty
    a_no_overrun: assert property (p_no_overrun) else $error("queue overrun");

    property p_idx_in_run;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> (r_idx < head.n_bytes);
    endproperty
    a_idx_in_run: assert property (p_idx_in_run) else $error("index past run");

    property p_cnt_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= (AW + 1)'(DEPTH);
    endproperty
    a_cnt_bound: assert property (p_cnt_bound) else $error("count above depth");

endmodule

// ===== hdl/box_chunk_offset_patcher.sv =====
// Top level: bytes are parsed and patched, results leave, one a cycle unless stalled.
// The block takes one byte of the box per cycle while o_stall is low; each
// request is parsed and patched in a single registered pass, so a new byte can
// follow every cycle. A byte completing a table entry gives 4 (32-bit table)
// or 8 (64-bit table) results, every other byte gives one, and the output
// side delivers one result per cycle while i_stall is low. Outside tables the
// sustained rate is then 1 byte a cycle; inside a table results outnumber
// bytes, so the output side sets the pace there. A small queue between parser
// and output absorbs the bursts; input stall rises when it holds two runs.
// The box length register is sampled at the first byte after reset.
module box_chunk_offset_patcher
    import bcop_pkg::*;
#(
    parameter int MAX_NESTING = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_run_end,
    output logic        o_stream_end,
    output logic [2:0]  o_error_code,
    output logic        o_offset_overflow
);
    logic [31:0] r_box_len;
    logic        run_valid, almost_full;
    t_run        run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_len <= 32'd16;
        end else if (i_cfg_we) begin
            r_box_len <= i_cfg_wdata;
        end
    end

    assign o_stall = almost_full;

    bcop_parser #(.MAX_NESTING(MAX_NESTING)) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box_len   (r_box_len),
        .i_in_valid  (i_valid && !o_stall),
        .i_in_byte   (i_in_byte),
        .o_run_valid (run_valid),
        .o_run       (run)
    );

    bcop_outq u_outq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_run_valid       (run_valid),
        .i_run             (run),
        .o_almost_full     (almost_full),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_byte            (o_out_byte),
        .o_byte_valid      (o_byte_valid),
        .o_run_end         (o_run_end),
        .o_stream_end      (o_stream_end),
        .o_error_code      (o_error_code),
        .o_offset_overflow (o_offset_overflow)
    );

endmodule
